@@ sv/gamepad_serial_poller_macros.svh @@
// assertion helpers for the checker file
`ifndef GAMEPAD_SERIAL_POLLER_MACROS_SVH
`define GAMEPAD_SERIAL_POLLER_MACROS_SVH

// same-cycle implication, sampled on clk_i and off while rst_ni is low
`define GSP_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define GSP_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/gsp_pkg.sv @@
package gsp_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int STORE_DEPTH = 9;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int BYTE_CNT_W  = 5;

  // sequencer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_CMD = 2'd0;
  localparam logic [1:0] REG_POLL_CMD  = 2'd1;
  localparam logic [1:0] REG_HALF      = 2'd2;
  localparam logic [1:0] REG_GAP       = 2'd3;

  localparam logic [7:0]  RST_FIRST_CMD = 8'h01;
  localparam logic [7:0]  RST_POLL_CMD  = 8'h42;
  localparam logic [15:0] RST_HALF      = 16'd5;
  localparam logic [15:0] RST_GAP       = 16'd1;

  localparam logic [7:0] ID_RED_MODE = 8'h73;
  localparam logic [7:0] LINK_IDLE   = 8'h80;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  typedef struct packed {
    logic [5:0] pad;
    logic       miso;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic       mode_red;
    logic       link_lost;
    logic [4:0] key_code;
    logic [15:0] buttons;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } dec_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  left_y;
    logic [7:0]  left_x;
    logic [7:0]  right_y;
    logic [7:0]  right_x;
    logic [15:0] buttons;
    logic [4:0]  key_code;
    logic        link_lost;
    logic        mode_red;
    logic        mosi;
    logic        sclk;
    logic        cs_n;
  } out_word_t;

endpackage

@@ sv/gamepad_serial_poller.sv @@
// the result word for a tick is registered in the output register, or in the skid entry while m_axis stalls
// throughput: one tick word per cycle while s_axis_tready_o is high, set by the single-pass sequencer update
// an output register plus one skid entry keep s_axis_tready_o high while one result waits
// reset (rst_ni low, asynchronous): sequencer idle, chip select high, frame store and
// counters cleared, configuration back to 0x01, 0x42, half period 5, byte gap 1
module gamepad_serial_poller
  import gsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // start_req, miso, zero pad
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cs_n, sclk, mosi, mode_red, link_lost, key_code, buttons, right_x, right_y,
  // left_x, left_y, zero pad
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic [7:0]  first_cmd_q, poll_cmd_q;
  logic [15:0] half_q, gap_q;

  logic [1:0]            phase_q, phase_d;
  store_t                store_q, store_d;
  logic [7:0]            shift_q, shift_d;
  logic [2:0]            bit_q, bit_d;
  logic [BYTE_CNT_W-1:0] byte_q, byte_d;
  logic [15:0]           tick_q, tick_d;

  in_word_t  in_w;
  out_word_t res;
  dec_t      dec;

  logic                  in_fire, out_fire;
  logic                  start_frame, end_byte, done;
  logic                  cs_n, sclk, mosi, cmd_bit;
  logic [1:0]            ph;
  store_t                store_c;
  logic [7:0]            shift_c, shift_n;
  logic [2:0]            bit_c;
  logic [BYTE_CNT_W-1:0] byte_c, byte_inc;
  logic [15:0]           tick_c, half_eff;
  logic [16:0]           tick_inc;

  logic [63:0] out_q, skid_q;
  logic        out_last_q, skid_last_q, out_v_q, skid_v_q;

  assign in_w     = in_word_t'(s_axis_tdata_i);
  assign half_eff = (half_q == '0) ? 16'd1 : half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cmd_q <= RST_FIRST_CMD;
      poll_cmd_q  <= RST_POLL_CMD;
      half_q      <= RST_HALF;
      gap_q       <= RST_GAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_CMD: first_cmd_q <= cfg_data_i[7:0];
        REG_POLL_CMD:  poll_cmd_q  <= cfg_data_i[7:0];
        REG_HALF:      half_q      <= cfg_data_i;
        REG_GAP:       gap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    start_frame = (phase_q == PH_IDLE) && in_w.start_req;
    ph      = start_frame ? PH_LOW : phase_q;
    store_c = start_frame ? '0 : store_q;
    shift_c = start_frame ? '0 : shift_q;
    bit_c   = start_frame ? '0 : bit_q;
    byte_c  = start_frame ? '0 : byte_q;
    tick_c  = start_frame ? '0 : tick_q;

    tick_inc = {1'b0, tick_c} + 17'd1;
    byte_inc = byte_c + BYTE_CNT_W'(1);

    case (byte_c)
      BYTE_CNT_W'(0): cmd_bit = first_cmd_q[bit_c];
      BYTE_CNT_W'(1): cmd_bit = poll_cmd_q[bit_c];
      default:        cmd_bit = 1'b0;
    endcase

    phase_d  = ph;
    store_d  = store_c;
    shift_n  = shift_c;
    bit_d    = bit_c;
    byte_d   = byte_c;
    tick_d   = tick_c;
    cs_n     = 1'b1;
    sclk     = 1'b1;
    mosi     = 1'b0;
    done     = 1'b0;
    end_byte = 1'b0;

    case (ph)
      PH_LOW: begin
        cs_n = 1'b0;
        sclk = 1'b0;
        mosi = cmd_bit;
        if (tick_inc >= {1'b0, half_eff}) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc[15:0];
        end
      end
      PH_HIGH: begin
        cs_n = 1'b0;
        mosi = cmd_bit;
        // sample on the rising edge, the first high tick
        if (tick_c == '0 && in_w.miso) begin
          shift_n[bit_c] = 1'b1;
        end
        if (tick_inc >= {1'b0, half_eff}) begin
          tick_d = '0;
          if (bit_c == 3'd7) begin
            if (gap_q != '0) begin
              phase_d = PH_GAP;
            end else begin
              end_byte = 1'b1;
            end
          end else begin
            bit_d   = bit_c + 3'd1;
            phase_d = PH_LOW;
          end
        end else begin
          tick_d = tick_inc[15:0];
        end
      end
      PH_GAP: begin
        cs_n = 1'b0;
        if (tick_inc >= {1'b0, gap_q}) begin
          end_byte = 1'b1;
        end else begin
          tick_d = tick_inc[15:0];
        end
      end
      default: ;
    endcase

    shift_d = shift_n;

    if (end_byte) begin
      // bytes beyond the store are clocked but dropped
      if (byte_c < BYTE_CNT_W'(STORE_DEPTH)) begin
        store_d[byte_c[STORE_IDX_W-1:0]] = shift_n;
      end
      byte_d  = byte_inc;
      shift_d = '0;
      bit_d   = '0;
      tick_d  = '0;
      if (byte_inc >= BYTE_CNT_W'(FRAME_BYTES)) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else begin
        phase_d = PH_LOW;
      end
    end
  end

  gsp_decode u_decode (
    .store_i (store_d),
    .dec_o   (dec)
  );

  always_comb begin
    res           = '0;
    res.cs_n      = cs_n;
    res.sclk      = sclk;
    res.mosi      = mosi;
    res.mode_red  = dec.mode_red;
    res.link_lost = dec.link_lost;
    res.key_code  = dec.key_code;
    res.buttons   = dec.buttons;
    res.right_x   = dec.right_x;
    res.right_y   = dec.right_y;
    res.left_x    = dec.left_x;
    res.left_y    = dec.left_y;
  end

  assign s_axis_tready_o = !skid_v_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      store_q <= '0;
      shift_q <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      tick_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      store_q <= store_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      tick_q  <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_v_q && !out_fire) begin
        skid_v_q <= 1'b1;
      end
      out_v_q <= 1'b1;
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q      <= skid_q;
        out_last_q <= skid_last_q;
      end
    end else if (in_fire) begin
      if (out_v_q && !out_fire) begin
        skid_q      <= res;
        skid_last_q <= done;
      end else begin
        out_q      <= res;
        out_last_q <= done;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ sv/gsp_decode.sv @@
module gsp_decode
  import gsp_pkg::*;
(
  input  store_t store_i,
  output dec_t   dec_o
);

  logic [15:0] buttons;
  logic [4:0]  key;

  assign buttons = {store_i[4], store_i[3]};

  // lowest released-low bit wins
  always_comb begin
    key = '0;
    for (int i = 15; i >= 0; i--) begin
      if (!buttons[i]) begin
        key = 5'(i + 1);
      end
    end
  end

  assign dec_o.mode_red  = (store_i[1] == ID_RED_MODE);
  assign dec_o.link_lost = (store_i[6] == LINK_IDLE) && (store_i[7] == LINK_IDLE) &&
                           (store_i[8] == LINK_IDLE);
  assign dec_o.key_code  = key;
  assign dec_o.buttons   = buttons;
  assign dec_o.right_x   = store_i[5];
  assign dec_o.right_y   = store_i[6];
  assign dec_o.left_x    = store_i[7];
  assign dec_o.left_y    = store_i[8];

endmodule

@@ sv/gsp_checker.sv @@
`include "gamepad_serial_poller_macros.svh"

module gsp_checker
  import gsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  out_word_t   ow;
  logic        last_w, idle_w, stall_w;
  logic [64:0] word_w;

  assign ow      = out_word_t'(m_axis_tdata_o);
  assign last_w  = m_axis_tvalid_o && m_axis_tlast_o;
  assign idle_w  = m_axis_tvalid_o && ow.cs_n;
  assign stall_w = m_axis_tvalid_o && !m_axis_tready_i;
  assign word_w  = {m_axis_tlast_o, m_axis_tdata_o};

  // a frame ends with select still low, clock high
  `GSP_ASSERT_IMP(a_done_in_frame, last_w, !ow.cs_n && ow.sclk, "frame end word outside frame")

  // idle bus: clock high, data low, no frame end flag
  `GSP_ASSERT_IMP(a_idle_lines, idle_w, ow.sclk && !ow.mosi && !m_axis_tlast_o, "bus not idle")

  // key code is zero when every button bit is high
  `GSP_ASSERT_IMP(a_key_none, m_axis_tvalid_o && (&ow.buttons), ow.key_code == 5'd0, "key code")

  `GSP_ASSERT_NXT(a_out_hold, stall_w, m_axis_tvalid_o && $stable(word_w), "stalled word changed")

endmodule

bind gamepad_serial_poller gsp_checker u_gsp_checker (.*);
